/* design/hkrd_pkg.sv */
// hkrd_pkg: shared types and constants for the keyboard report differ.
// Used by hkrd_ctrl, hkrd_datapath and the core; depends on nothing.
`timescale 1ns / 1ps

package hkrd_pkg;

	// item kinds on the input tuser
	localparam logic [1:0] KIND_REPORT = 2'd0;
	localparam logic [1:0] KIND_TICK   = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// configuration register indexes
	localparam logic CFG_DELAY = 1'b0;
	localparam logic CFG_RATE  = 1'b1;

	localparam logic [15:0] DELAY_RESET = 16'd500;
	localparam logic [15:0] RATE_RESET  = 16'd33;

	// usage codes with special handling
	localparam logic [7:0] CODE_NUMLOCK  = 8'h53;
	localparam logic [7:0] CODE_CAPSLOCK = 8'h39;
	localparam logic [7:0] CODE_DEL      = 8'h4C;
	localparam logic [7:0] CODE_KP_DEL   = 8'h63;
	localparam logic [7:0] CODE_LCTRL    = 8'hE0;
	localparam logic [7:0] CODE_RCTRL    = 8'hE4;
	localparam logic [7:0] CODE_LALT     = 8'hE2;
	localparam logic [7:0] CODE_RALT     = 8'hE6;
	localparam logic [7:0] CODE_MIN_KEY  = 8'h04;

	// scan positions: 8 modifiers, 6 release slots, 6 press slots
	localparam int          NUM_POS  = 20;
	localparam int          POS_W    = 5;
	localparam logic [4:0]  MOD_END  = 5'd8;
	localparam logic [4:0]  REL_END  = 5'd14;
	localparam logic [4:0]  REL_LAST = 5'd13;
	localparam logic [4:0]  POS_LAST = 5'd19;

	// modifier scan order: LCtrl, RCtrl, LShift, RShift, LAlt, RAlt, LGUI, RGUI
	localparam logic [7:0] MOD_MASK [8] = '{8'h01, 8'h10, 8'h02, 8'h20,
		8'h04, 8'h40, 8'h08, 8'h80};
	localparam logic [7:0] MOD_CODE [8] = '{8'hE0, 8'hE4, 8'hE1, 8'hE5,
		8'hE2, 8'hE6, 8'hE3, 8'hE7};

	typedef struct packed {
		logic             load;    // capture input beat
		logic             start;   // build event mask, clear pending repeat key
		logic             step;    // handle scan position idx
		logic             finish;  // store report, arm repeat
		logic             tick;    // run repeat timer
		logic             err;     // transfer error: drop repeat
		logic [POS_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       same;      // report equals stored one
		logic       bit_set;   // event at current scan position
		logic       out_free;  // output register can take a beat
		logic       tick_emit; // tick would emit a repeat press
	} stat_t;

endpackage

/* design/hkrd_ctrl.sv */
// hkrd_ctrl: sequencer for the report differ.
// Depends on hkrd_pkg; drives hkrd_datapath through cmd_t, reads stat_t.
`timescale 1ns / 1ps

module hkrd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  hkrd_pkg::stat_t st,
	output hkrd_pkg::cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DISP = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_TICK = 3'd4;

	logic [2:0]                 state_q, state_d;
	logic [hkrd_pkg::POS_W-1:0] idx_q, idx_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		cmd        = '0;
		cmd.idx    = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISP;
				end
			end
			ST_DISP: begin
				unique case (st.kind)
					hkrd_pkg::KIND_REPORT: begin
						if (st.same) begin
							state_d = ST_IDLE;
						end else begin
							cmd.start = 1'b1;
							idx_d     = '0;
							state_d   = ST_SCAN;
						end
					end
					hkrd_pkg::KIND_TICK: state_d = ST_TICK;
					hkrd_pkg::KIND_ERROR: begin
						cmd.err = 1'b1;
						state_d = ST_IDLE;
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_SCAN: begin
				if (!st.bit_set || st.out_free) begin
					cmd.step = 1'b1;
					if (idx_q == hkrd_pkg::POS_LAST) begin
						state_d = ST_FIN;
					end else begin
						idx_d = idx_q + 5'd1;
					end
				end
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_TICK: begin
				if (!st.tick_emit || st.out_free) begin
					cmd.tick = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

endmodule

/* design/hkrd_datapath.sv */
// hkrd_datapath: report store, event mask, repeat timer, output register.
// Depends on hkrd_pkg; commanded by hkrd_ctrl.
`timescale 1ns / 1ps

module hkrd_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  hkrd_pkg::cmd_t  cmd,
	output hkrd_pkg::stat_t st,
	input  logic [1:0]      in_kind,
	input  logic [63:0]     in_report,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [15:0]     cfg_wdata,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_code,
	output logic            out_down,
	output logic            out_rst,
	output logic            out_last
);

	logic [15:0] delay_q, rate_q;
	logic [1:0]  kind_q;
	logic [7:0]  cur_q  [8];
	logic [7:0]  prev_q [8];

	logic [hkrd_pkg::NUM_POS-1:0] mask_q, mask_d, mask_clr;
	logic [7:0]  rep_code_q, new_rep_q;
	logic [15:0] countdown_q;
	logic        armed_q, ctrl_q, alt_q;

	logic        same;
	logic        bit_set;
	logic        is_mod, is_rel, is_press;
	logic [2:0]  slot_sel;
	logic [4:0]  sel_wide;
	logic [7:0]  evt_code;
	logic        evt_down, evt_rst;
	logic [7:0]  code_step;
	logic        armed_step;
	logic        tick_emit;
	logic        emit;
	logic [15:0] delay1, rate1;

	// change detect and event mask
	always_comb begin
		logic found_c, found_p;
		same   = 1'b1;
		mask_d = '0;
		for (int b = 0; b < 8; b++) begin
			if (cur_q[b] != prev_q[b]) same = 1'b0;
		end
		for (int m = 0; m < 8; m++) begin
			mask_d[m] = |((cur_q[0] ^ prev_q[0]) & hkrd_pkg::MOD_MASK[m]);
		end
		for (int j = 0; j < 6; j++) begin
			found_c = 1'b0;
			found_p = 1'b0;
			for (int k = 0; k < 6; k++) begin
				if (cur_q[k+2] == prev_q[j+2]) found_c = 1'b1;
				if (prev_q[k+2] == cur_q[j+2]) found_p = 1'b1;
			end
			mask_d[8+j]  = (prev_q[j+2] >= hkrd_pkg::CODE_MIN_KEY) && !found_c;
			mask_d[14+j] = (cur_q[j+2] >= hkrd_pkg::CODE_MIN_KEY) && !found_p;
		end
	end

	// event at the current scan position
	always_comb begin
		is_mod   = (cmd.idx < hkrd_pkg::MOD_END);
		is_rel   = !is_mod && (cmd.idx < hkrd_pkg::REL_END);
		is_press = !is_mod && !is_rel;
		bit_set  = mask_q[cmd.idx];
		mask_clr = mask_q;
		mask_clr[cmd.idx] = 1'b0;
		// release slots 8..13 map to bytes 2..7, press slots 14..19 likewise
		sel_wide = is_rel ? (cmd.idx - 5'd6) : (cmd.idx - 5'd12);
		slot_sel = sel_wide[2:0];
		if (is_mod) begin
			evt_code = hkrd_pkg::MOD_CODE[cmd.idx[2:0]];
			evt_down = |(cur_q[0] & hkrd_pkg::MOD_MASK[cmd.idx[2:0]]);
		end else if (is_rel) begin
			evt_code = prev_q[slot_sel];
			evt_down = 1'b0;
		end else begin
			evt_code = cur_q[slot_sel];
			evt_down = 1'b1;
		end
		evt_rst = evt_down && ctrl_q && alt_q &&
			((evt_code == hkrd_pkg::CODE_DEL) || (evt_code == hkrd_pkg::CODE_KP_DEL));

		code_step  = rep_code_q;
		armed_step = armed_q;
		if (is_rel && bit_set && (evt_code == rep_code_q)) code_step = '0;
		if (is_press && bit_set) begin
			code_step  = '0;
			armed_step = 1'b0;
		end
		if ((cmd.idx == hkrd_pkg::REL_LAST) && (code_step == '0)) armed_step = 1'b0;
	end

	assign delay1    = (delay_q == '0) ? 16'd1 : delay_q;
	assign rate1     = (rate_q == '0) ? 16'd1 : rate_q;
	assign tick_emit = armed_q && (countdown_q <= 16'd1) && (rep_code_q != '0);
	assign emit      = (cmd.step && bit_set) || (cmd.tick && tick_emit);

	assign st.kind      = kind_q;
	assign st.same      = same;
	assign st.bit_set   = bit_set;
	assign st.out_free  = !out_valid || out_ready;
	assign st.tick_emit = tick_emit;

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_kind;
			for (int b = 0; b < 8; b++) cur_q[b] <= in_report[8*b +: 8];
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= hkrd_pkg::DELAY_RESET;
			rate_q  <= hkrd_pkg::RATE_RESET;
		end else if (cfg_we) begin
			if (cfg_index == hkrd_pkg::CFG_DELAY) delay_q <= cfg_wdata;
			else rate_q <= cfg_wdata;
		end
	end

	// keyboard state and repeat timer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < 8; b++) prev_q[b] <= '0;
			mask_q      <= '0;
			new_rep_q   <= '0;
			rep_code_q  <= '0;
			countdown_q <= '0;
			armed_q     <= 1'b0;
			ctrl_q      <= 1'b0;
			alt_q       <= 1'b0;
		end else begin
			if (cmd.start) begin
				mask_q    <= mask_d;
				new_rep_q <= '0;
			end
			if (cmd.step) begin
				mask_q     <= mask_clr;
				rep_code_q <= code_step;
				armed_q    <= armed_step;
				if (bit_set) begin
					if ((evt_code == hkrd_pkg::CODE_LCTRL) ||
						(evt_code == hkrd_pkg::CODE_RCTRL)) begin
						ctrl_q <= evt_down;
					end
					if ((evt_code == hkrd_pkg::CODE_LALT) ||
						(evt_code == hkrd_pkg::CODE_RALT)) begin
						alt_q <= evt_down;
					end
					if (is_press && (evt_code != hkrd_pkg::CODE_NUMLOCK) &&
						(evt_code != hkrd_pkg::CODE_CAPSLOCK)) begin
						new_rep_q <= evt_code;
					end
				end
			end
			if (cmd.finish) begin
				for (int b = 0; b < 8; b++) prev_q[b] <= cur_q[b];
				if (new_rep_q != '0) begin
					rep_code_q  <= new_rep_q;
					countdown_q <= delay1;
					armed_q     <= 1'b1;
				end
			end
			if (cmd.tick && armed_q) begin
				if (countdown_q > 16'd1) begin
					countdown_q <= countdown_q - 16'd1;
				end else if (rep_code_q == '0) begin
					armed_q     <= 1'b0;
					countdown_q <= '0;
				end else begin
					countdown_q <= rate1;
				end
			end
			if (cmd.err) begin
				rep_code_q  <= '0;
				countdown_q <= '0;
				armed_q     <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (cmd.tick) begin
				out_code <= rep_code_q;
				out_down <= 1'b1;
				out_rst  <= 1'b0;
				out_last <= 1'b1;
			end else begin
				out_code <= evt_code;
				out_down <= evt_down;
				out_rst  <= evt_rst;
				out_last <= (mask_clr == '0);
			end
		end
	end

endmodule

/* design/hid_keyboard_report_differ_core.sv */
// hid_keyboard_report_differ_core: top level of the HID boot keyboard report differ.
// Instantiates hkrd_ctrl and hkrd_datapath; uses hkrd_pkg.
// Report beat: accept, dispatch, scan of the 20 positions, store, then ready again;
// a scan position with an event waits while the output register is full. A tick
// goes through dispatch and the timer step; an error or unchanged report ends at dispatch.
// The 20-position scan (8 modifiers, 6 release slots, 6 press slots) sets the rate.
// Async active-low reset: stored report zero, no repeat key, delay 500, rate 33.
`timescale 1ns / 1ps

module hid_keyboard_report_differ_core (
	input  logic        clk,
	input  logic        arst_n,
	// input beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // modifier_byte, reserved_byte, key_slot_0..key_slot_5
	input  logic [1:0]  s_tuser,  // kind
	// event beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // event_code[7:0], event_down[8], reset_request[9], zero
	output logic        m_tuser,  // event_valid
	output logic        m_tlast,
	// configuration writes
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata
);

	hkrd_pkg::cmd_t  cmd;
	hkrd_pkg::stat_t st;
	logic [7:0]      ev_code;
	logic            ev_down, ev_rst;

	// controller: one beat in flight, steps the scan, waits on the output register
	hkrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// datapath: stored report, mask, Ctrl/Alt tracking, typematic timer
	hkrd_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_kind   (s_tuser),
		.in_report (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_code  (ev_code),
		.out_down  (ev_down),
		.out_rst   (ev_rst),
		.out_last  (m_tlast)
	);

	// every emitted beat carries a key event
	assign m_tuser = 1'b1;
	assign m_tdata = {6'b0, ev_rst, ev_down, ev_code};

endmodule

/* design/hkrd_checker.sv */
// hkrd_checker: port-level assertions for hid_keyboard_report_differ_core.
// Uses only top-level ports; bound to the core at the end of this file.
`timescale 1ns / 1ps

module hkrd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// a stalled event beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("event beat changed while stalled");

	// every beat is a key event
	a_evt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser)
		else $error("event beat without event flag");

	// reset request only on a Delete press
	a_rst: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[9] |-> m_tdata[8] &&
		((m_tdata[7:0] == hkrd_pkg::CODE_DEL) || (m_tdata[7:0] == hkrd_pkg::CODE_KP_DEL)))
		else $error("reset request on a non-Delete event");

	// one item at a time: busy right after an input beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

endmodule

bind hid_keyboard_report_differ_core hkrd_checker u_hkrd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
